/* hdl/debounced_fault_level_monitor_macros.svh */
// Assertion macros for the debounced fault level monitor checker.
`ifndef DEBOUNCED_FAULT_LEVEL_MONITOR_MACROS_SVH
`define DEBOUNCED_FAULT_LEVEL_MONITOR_MACROS_SVH

// Checked only while out of reset.
`define DFLM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define DFLM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hdl/dflm_pkg.sv */
// Shared types and constants of the debounced fault level monitor.
`default_nettype none

package dflm_pkg;

    localparam int LIMIT_W     = 31;
    localparam int TIMEOUT_W   = 16;
    localparam int RUN_W       = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int OUT_TDATA_W = 16;

    typedef logic [1:0] level_t;

    localparam level_t LVL_NOMINAL     = 2'd0;
    localparam level_t LVL_COMPLIANT   = 2'd1;
    localparam level_t LVL_TORQUE_LIM  = 2'd2;
    localparam level_t LVL_SAFE_STOP   = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_TORQUE_L1 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TORQUE_L2 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TORQUE_L3 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_L1  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_L2  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_L3  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT   = 3'd6;

    localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 31'h7FFF_FFFF;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10;

    typedef struct packed {
        logic [LIMIT_W-1:0] level3;
        logic [LIMIT_W-1:0] level2;
        logic [LIMIT_W-1:0] level1;
    } limit_set_t;

    typedef struct packed {
        limit_set_t             torque;
        limit_set_t             speed;
        logic [TIMEOUT_W-1:0]   timeout_ticks;
    } cfg_t;

    function automatic logic [RUN_W-1:0] run_bump(input logic [RUN_W-1:0] run);
        return (run == '1) ? run : RUN_W'(run + 1'b1);
    endfunction

endpackage

`default_nettype wire

/* hdl/debounced_fault_level_monitor.sv */
// Top level of the debounced fault level monitor.
//
// Accepts one transaction per clock while the output is not stalled and
// returns exactly one result per transaction. Each transaction is captured
// in the input register and its result in the result register, which
// drives the master side. A stalled output holds one result and one waiting
// input, then drops s_axis_tready.
// The slave side takes a status sample (tuser 0) or a watchdog tick (tuser 1).
// A sample is graded, debounced and compared with the latched level in one
// pass between the input register and the result register; the same pass
// updates the debounce run counters, latched level and watchdog state, so
// back-to-back transactions see the state left by the previous one. The
// configuration port writes one register per clock and must only be used
// while no transaction is in flight.
`default_nettype none

module debounced_fault_level_monitor
    import dflm_pkg::*;
#(
    parameter int MILD_DEBOUNCE  = 3,
    parameter int LIMIT_DEBOUNCE = 3,
    parameter int HALT_DEBOUNCE  = 3,
    parameter int SAMPLE_WIDTH   = 32
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: torque, joint_speed, zero pad
    input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // tuser: action (0 sample, 1 tick)
    input  wire logic                  s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: requested_level, latched_level, instant_level, debounced_grade,
    //        watchdog_fired, zero pad
    output logic [OUT_TDATA_W-1:0]     m_axis_tdata
);

    cfg_t   cfg;
    level_t torque_level;
    level_t speed_level;

    logic                    in_valid_reg;
    logic                    in_tick_reg;
    logic [SAMPLE_WIDTH-1:0] in_torque_reg;
    logic [SAMPLE_WIDTH-1:0] in_speed_reg;

    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_tdata_reg;
    logic [OUT_TDATA_W-1:0]  out_tdata_next;

    level_t                  latched_reg,     latched_next;
    logic [RUN_W-1:0]        mild_run_reg,    mild_run_next;
    logic [RUN_W-1:0]        limit_run_reg,   limit_run_next;
    logic [RUN_W-1:0]        halt_run_reg,    halt_run_next;
    logic                    seen_reg,        seen_next;
    logic                    tmo_latched_reg, tmo_latched_next;
    logic [TIMEOUT_W-1:0]    ticks_reg,       ticks_next;

    level_t                  instant;
    level_t                  debounced;
    level_t                  request;
    logic                    fired;

    logic                    advance;
    logic                    process;

    dflm_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dflm_grade #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_grade_torque (
        .sample (in_torque_reg),
        .limits (cfg.torque),
        .level  (torque_level)
    );

    dflm_grade #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_grade_speed (
        .sample (in_speed_reg),
        .limits (cfg.speed),
        .level  (speed_level)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_tick_reg   <= s_axis_tuser;
            in_torque_reg <= s_axis_tdata[SAMPLE_WIDTH-1:0];
            in_speed_reg  <= s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        end
    end

    always_comb begin
        latched_next     = latched_reg;
        mild_run_next    = mild_run_reg;
        limit_run_next   = limit_run_reg;
        halt_run_next    = halt_run_reg;
        seen_next        = seen_reg;
        tmo_latched_next = tmo_latched_reg;
        ticks_next       = ticks_reg;
        instant          = LVL_NOMINAL;
        debounced        = LVL_NOMINAL;
        request          = LVL_NOMINAL;
        fired            = 1'b0;

        if (!in_tick_reg) begin
            seen_next        = 1'b1;
            tmo_latched_next = 1'b0;
            ticks_next       = '0;
            instant = (torque_level >= speed_level) ? torque_level : speed_level;

            case (instant)
                LVL_SAFE_STOP: begin
                    halt_run_next  = run_bump(halt_run_reg);
                    limit_run_next = '0;
                    mild_run_next  = '0;
                end
                LVL_TORQUE_LIM: begin
                    limit_run_next = run_bump(limit_run_reg);
                    halt_run_next  = '0;
                    mild_run_next  = '0;
                end
                LVL_COMPLIANT: begin
                    mild_run_next  = run_bump(mild_run_reg);
                    limit_run_next = '0;
                    halt_run_next  = '0;
                end
                default: begin
                    mild_run_next  = '0;
                    limit_run_next = '0;
                    halt_run_next  = '0;
                end
            endcase

            if (halt_run_next >= RUN_W'(HALT_DEBOUNCE)) begin
                debounced = LVL_SAFE_STOP;
            end else if (limit_run_next >= RUN_W'(LIMIT_DEBOUNCE)) begin
                debounced = LVL_TORQUE_LIM;
            end else if (mild_run_next >= RUN_W'(MILD_DEBOUNCE)) begin
                debounced = LVL_COMPLIANT;
            end

            if (debounced > latched_reg) begin
                latched_next = debounced;
                request      = debounced;
            end
        end else if (seen_reg) begin
            ticks_next = run_bump(ticks_reg);
            if (ticks_next >= cfg.timeout_ticks && !tmo_latched_reg) begin
                tmo_latched_next = 1'b1;
                fired            = 1'b1;
                if (latched_reg != LVL_SAFE_STOP) begin
                    latched_next = LVL_SAFE_STOP;
                    request      = LVL_SAFE_STOP;
                end
            end
        end
    end

    assign out_tdata_next = OUT_TDATA_W'({fired, debounced, instant, latched_next, request});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_reg     <= LVL_NOMINAL;
            mild_run_reg    <= '0;
            limit_run_reg   <= '0;
            halt_run_reg    <= '0;
            seen_reg        <= 1'b0;
            tmo_latched_reg <= 1'b0;
            ticks_reg       <= '0;
        end else if (process) begin
            latched_reg     <= latched_next;
            mild_run_reg    <= mild_run_next;
            limit_run_reg   <= limit_run_next;
            halt_run_reg    <= halt_run_next;
            seen_reg        <= seen_next;
            tmo_latched_reg <= tmo_latched_next;
            ticks_reg       <= ticks_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            out_tdata_reg <= out_tdata_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;

endmodule

`default_nettype wire

/* hdl/dflm_cfg_regs.sv */
// Configuration register bank: threshold limits and watchdog timeout.
`default_nettype none

module dflm_cfg_regs
    import dflm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_TORQUE_L1: cfg_next.torque.level1 = cfg_wdata[LIMIT_W-1:0];
                REG_TORQUE_L2: cfg_next.torque.level2 = cfg_wdata[LIMIT_W-1:0];
                REG_TORQUE_L3: cfg_next.torque.level3 = cfg_wdata[LIMIT_W-1:0];
                REG_SPEED_L1:  cfg_next.speed.level1  = cfg_wdata[LIMIT_W-1:0];
                REG_SPEED_L2:  cfg_next.speed.level2  = cfg_wdata[LIMIT_W-1:0];
                REG_SPEED_L3:  cfg_next.speed.level3  = cfg_wdata[LIMIT_W-1:0];
                REG_TIMEOUT:   cfg_next.timeout_ticks = cfg_wdata[TIMEOUT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.torque.level1 <= LIMIT_RESET;
            cfg_reg.torque.level2 <= LIMIT_RESET;
            cfg_reg.torque.level3 <= LIMIT_RESET;
            cfg_reg.speed.level1  <= LIMIT_RESET;
            cfg_reg.speed.level2  <= LIMIT_RESET;
            cfg_reg.speed.level3  <= LIMIT_RESET;
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/dflm_grade.sv */
// Saturating magnitude of one signed sample graded against three limits.
`default_nettype none

module dflm_grade
    import dflm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
)
(
    input  wire logic [SAMPLE_WIDTH-1:0] sample,
    input  limit_set_t                   limits,
    output level_t                       level
);

    localparam int CMP_W = (SAMPLE_WIDTH > LIMIT_W) ? SAMPLE_WIDTH : LIMIT_W;

    logic [SAMPLE_WIDTH-1:0] negated;
    logic [SAMPLE_WIDTH-1:0] magnitude;
    logic [CMP_W-1:0]        mag_ext;
    logic [CMP_W-1:0]        lim1;
    logic [CMP_W-1:0]        lim2;
    logic [CMP_W-1:0]        lim3;

    always_comb begin
        negated = SAMPLE_WIDTH'(~sample + 1'b1);
        if (!sample[SAMPLE_WIDTH-1]) begin
            magnitude = sample;
        end else if (negated[SAMPLE_WIDTH-1]) begin
            // most negative value saturates to the largest positive one
            magnitude = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end else begin
            magnitude = negated;
        end
    end

    assign mag_ext = CMP_W'(magnitude);
    assign lim1    = CMP_W'(limits.level1);
    assign lim2    = CMP_W'(limits.level2);
    assign lim3    = CMP_W'(limits.level3);

    always_comb begin
        if (mag_ext >= lim3) begin
            level = LVL_SAFE_STOP;
        end else if (mag_ext >= lim2) begin
            level = LVL_TORQUE_LIM;
        end else if (mag_ext >= lim1) begin
            level = LVL_COMPLIANT;
        end else begin
            level = LVL_NOMINAL;
        end
    end

endmodule

`default_nettype wire

/* hdl/dflm_checker.sv */
// Port-level checker for the debounced fault level monitor, with its bind.
`default_nettype none

`include "debounced_fault_level_monitor_macros.svh"

module dflm_checker
    import dflm_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    level_t req;
    level_t latched;
    level_t inst;
    level_t deb;
    logic   fired;

    assign req     = m_axis_tdata[1:0];
    assign latched = m_axis_tdata[3:2];
    assign inst    = m_axis_tdata[5:4];
    assign deb     = m_axis_tdata[7:6];
    assign fired   = m_axis_tdata[8];

    `DFLM_ASSERT_ALWAYS(a_reset_clears_valid, !aresetn |=> !m_axis_tvalid, "result valid after reset")

    `DFLM_ASSERT(a_stall_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    `DFLM_ASSERT(a_request_is_latched, m_axis_tvalid |-> (req == LVL_NOMINAL) || (req == latched), "request differs from latched level")

    `DFLM_ASSERT(a_debounce_matches_instant, m_axis_tvalid |-> (deb == LVL_NOMINAL) || (deb == inst), "debounced grade not instant level")

    `DFLM_ASSERT(a_fire_is_tick, m_axis_tvalid && fired |-> (latched == LVL_SAFE_STOP) && (inst == LVL_NOMINAL) && (deb == LVL_NOMINAL), "watchdog fire inconsistent")

endmodule

bind debounced_fault_level_monitor dflm_checker u_dflm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking stream bench for the debounced fault level monitor with its own level predictor.
module tb_top;
    import dflm_pkg::*;

    localparam int MILD_LEN    = 3;
    localparam int LIMIT_LEN   = 3;
    localparam int HALT_LEN    = 3;
    localparam int SAMPLE_W    = 32;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 280;
    localparam int MAX_PRINTS  = 40;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;
    localparam logic [15:0] RUN_SAT = 16'hFFFF;

    typedef struct packed {
        logic        action;
        logic [31:0] trq;
        logic [31:0] spd;
    } status_item_t;

    // result fields from the lowest bit up: req, latched, inst, deb, fired
    typedef struct packed {
        logic   fired;
        level_t deb;
        level_t inst;
        level_t latched;
        level_t req;
    } level_report_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]     cfg_addr = '0;
    logic [CFG_DATA_W-1:0]     cfg_wdata = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [2*SAMPLE_W-1:0]     s_axis_tdata = '0;
    logic                      s_axis_tuser = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;

    // shadow of the configuration
    logic [LIMIT_W-1:0]   trq_lim [1:3];
    logic [LIMIT_W-1:0]   spd_lim [1:3];
    logic [TIMEOUT_W-1:0] tmo_ticks;

    // predicted block state
    level_t      latched_lvl;
    logic [15:0] mild_cnt, limit_cnt, halt_cnt;
    logic        seen_status, wd_tripped;
    logic [15:0] idle_ticks;

    status_item_t  pending_items[$];
    level_report_t level_q[$];

    logic in_hs = 1'b0;
    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    int   hold_req = 0, hold_ack = 0, hold_left = 0;
    int   errors = 0, cycle_cnt = 0;
    int   n_samples = 0, n_ticks = 0, n_results = 0, n_requests = 0, n_fires = 0;

    debounced_fault_level_monitor #(
        .MILD_DEBOUNCE (MILD_LEN),
        .LIMIT_DEBOUNCE(LIMIT_LEN),
        .HALT_DEBOUNCE (HALT_LEN),
        .SAMPLE_WIDTH  (SAMPLE_W)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [31:0] magnitude_of(input logic [31:0] v);
        if (v == 32'h8000_0000)
            return 32'h7FFF_FFFF;
        return v[31] ? 32'(~v + 32'd1) : v;
    endfunction

    function automatic level_t grade_of(input logic [31:0] m,
                                        input logic [LIMIT_W-1:0] l1, l2, l3);
        if (m >= {1'b0, l3}) return LVL_SAFE_STOP;
        if (m >= {1'b0, l2}) return LVL_TORQUE_LIM;
        if (m >= {1'b0, l1}) return LVL_COMPLIANT;
        return LVL_NOMINAL;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == RUN_SAT) ? v : v + 16'd1;
    endfunction

    function automatic level_report_t predict_levels(input logic action,
                                                     input logic [31:0] trq, spd);
        level_report_t r;
        level_t gt, gv;
        r = '0;
        if (action == ACT_SAMPLE) begin
            seen_status = 1'b1;
            wd_tripped  = 1'b0;
            idle_ticks  = '0;
            gt = grade_of(magnitude_of(trq), trq_lim[1], trq_lim[2], trq_lim[3]);
            gv = grade_of(magnitude_of(spd), spd_lim[1], spd_lim[2], spd_lim[3]);
            r.inst = (gt >= gv) ? gt : gv;
            case (r.inst)
                LVL_SAFE_STOP: begin
                    halt_cnt = sat_inc(halt_cnt); limit_cnt = '0; mild_cnt = '0;
                end
                LVL_TORQUE_LIM: begin
                    limit_cnt = sat_inc(limit_cnt); halt_cnt = '0; mild_cnt = '0;
                end
                LVL_COMPLIANT: begin
                    mild_cnt = sat_inc(mild_cnt); limit_cnt = '0; halt_cnt = '0;
                end
                default: begin
                    mild_cnt = '0; limit_cnt = '0; halt_cnt = '0;
                end
            endcase
            if (halt_cnt >= HALT_LEN)       r.deb = LVL_SAFE_STOP;
            else if (limit_cnt >= LIMIT_LEN) r.deb = LVL_TORQUE_LIM;
            else if (mild_cnt >= MILD_LEN)   r.deb = LVL_COMPLIANT;
            if (r.deb > latched_lvl) begin
                latched_lvl = r.deb;
                r.req = r.deb;
            end
        end else if (seen_status) begin
            idle_ticks = sat_inc(idle_ticks);
            if (idle_ticks >= tmo_ticks && !wd_tripped) begin
                wd_tripped = 1'b1;
                r.fired = 1'b1;
                if (latched_lvl != LVL_SAFE_STOP) begin
                    latched_lvl = LVL_SAFE_STOP;
                    r.req = LVL_SAFE_STOP;
                end
            end
        end
        r.latched = latched_lvl;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      n_results, name, got, want));
    endtask

    // input transactions feed the predictor, output transactions are checked
    always @(posedge aclk) begin : monitor
        level_report_t want, got;
        if (!aresetn) begin
            in_hs <= 1'b0;
        end else begin
            in_hs <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                want = predict_levels(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
                level_q.push_back(want);
                if (s_axis_tuser == ACT_TICK) n_ticks++;
                else n_samples++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[8:0];
                n_results++;
                if (level_q.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want = level_q.pop_front();
                    check_field("requested_level", got.req, want.req);
                    check_field("latched_level", got.latched, want.latched);
                    check_field("instant_level", got.inst, want.inst);
                    check_field("debounced_grade", got.deb, want.deb);
                    check_field("watchdog_fired", got.fired, want.fired);
                    check_field("pad bits", m_axis_tdata[OUT_TDATA_W-1:9], 0);
                    if (want.req != LVL_NOMINAL) n_requests++;
                    if (want.fired) n_fires++;
                end
            end
        end
    end

    always @(negedge aclk) begin : driver
        status_item_t nxt;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_hs) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                nxt = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.spd, nxt.trq};
                s_axis_tuser  <= nxt.action;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : receiver
        if (hold_ack != hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_ack  = hold_req;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, level_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_TORQUE_L1: trq_lim[1] = val;
            REG_TORQUE_L2: trq_lim[2] = val;
            REG_TORQUE_L3: trq_lim[3] = val;
            REG_SPEED_L1:  spd_lim[1] = val;
            REG_SPEED_L2:  spd_lim[2] = val;
            REG_SPEED_L3:  spd_lim[3] = val;
            REG_TIMEOUT:   tmo_ticks  = val[TIMEOUT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_limits(input bit is_speed, input logic [LIMIT_W-1:0] l1, l2, l3);
        write_reg(is_speed ? REG_SPEED_L1 : REG_TORQUE_L1, l1);
        write_reg(is_speed ? REG_SPEED_L2 : REG_TORQUE_L2, l2);
        write_reg(is_speed ? REG_SPEED_L3 : REG_TORQUE_L3, l3);
    endtask

    task automatic write_ascending(input bit is_speed);
        logic [LIMIT_W-1:0] a, b, c;
        a = LIMIT_W'($urandom_range(32'h100, 32'h2_0000));
        b = LIMIT_W'(a + $urandom_range(0, 32'h20_0000));
        c = LIMIT_W'(b + $urandom_range(1, 32'h200_0000));
        write_limits(is_speed, a, b, c);
    endtask

    task automatic push_sample(input logic [31:0] trq, input logic [31:0] spd);
        pending_items.push_back('{ACT_SAMPLE, trq, spd});
    endtask

    task automatic push_tick();
        pending_items.push_back('{ACT_TICK, $urandom, $urandom});
    endtask

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // value with magnitude on or just above the level's limit, or under limit one for level 0
    function automatic logic [31:0] near_level(input int lvl, input logic [LIMIT_W-1:0] l1, l2, l3);
        logic [31:0] base, m;
        if (lvl == 0) begin
            if (l1 == 0)                 m = '0;
            else if ($urandom_range(0, 1)) m = {1'b0, l1} - 32'd1;
            else                         m = $urandom_range(0, {1'b0, l1} - 32'd1);
        end else begin
            base = (lvl == 1) ? {1'b0, l1} : (lvl == 2) ? {1'b0, l2} : {1'b0, l3};
            m = (base > 32'h7FFF_FFFC) ? base : base + $urandom_range(0, 2);
        end
        if (m == 32'h7FFF_FFFF && $urandom_range(0, 1))
            return 32'h8000_0000;
        return $urandom_range(0, 1) ? 32'(~m + 32'd1) : m;
    endfunction

    task automatic gen_random(input int n);
        int made, len, lvl, other;
        made = 0;
        while (made < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    lvl = $urandom_range(0, 3);
                    len = $urandom_range(1, 5);
                    repeat (len) begin
                        other = $urandom_range(0, lvl);
                        if ($urandom_range(0, 1))
                            push_sample(near_level(lvl, trq_lim[1], trq_lim[2], trq_lim[3]),
                                        near_level(other, spd_lim[1], spd_lim[2], spd_lim[3]));
                        else
                            push_sample(near_level(other, trq_lim[1], trq_lim[2], trq_lim[3]),
                                        near_level(lvl, spd_lim[1], spd_lim[2], spd_lim[3]));
                    end
                    made += len;
                end
                6, 7: begin
                    len = $urandom_range(1, (tmo_ticks > 16'd38) ? 40 : int'(tmo_ticks) + 2);
                    repeat (len) push_tick();
                    made += len;
                end
                8: begin
                    push_sample($urandom, $urandom);
                    made++;
                end
                default: begin
                    push_sample(extreme_value(), extreme_value());
                    made++;
                end
            endcase
        end
    endtask

    task automatic start_phase(input int sidle, input int rstall);
        @(posedge aclk);
        sender_idle_pct = sidle;
        recv_stall_pct  = rstall;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || s_axis_tvalid || level_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        logic [LIMIT_W-1:0] a, b, c;
        trq_lim[1] = LIMIT_RESET; trq_lim[2] = LIMIT_RESET; trq_lim[3] = LIMIT_RESET;
        spd_lim[1] = LIMIT_RESET; spd_lim[2] = LIMIT_RESET; spd_lim[3] = LIMIT_RESET;
        tmo_ticks   = TIMEOUT_RESET;
        latched_lvl = LVL_NOMINAL;
        mild_cnt = '0; limit_cnt = '0; halt_cnt = '0;
        seen_status = 1'b0; wd_tripped = 1'b0; idle_ticks = '0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: grading extremes, escalation to each level, watchdog cases
        write_limits(1'b0, 31'h0001_0000, 31'h000A_0000, 31'h0064_0000);
        write_limits(1'b1, 31'h0002_0000, 31'h0014_0000, 31'h00C8_0000);
        write_reg(REG_TIMEOUT, 31'd4);
        write_reg(REG_UNUSED, 31'h5A5A_1234);
        start_phase(0, 0);
        push_tick();
        push_tick();
        push_sample(32'h0000_0000, 32'h0000_0000);
        push_sample(32'h7FFF_FFFF, 32'h0000_0000);
        push_sample(32'h0000_0000, 32'h8000_0000);
        push_sample(32'hFFFF_0000, 32'h0000_0000);
        push_sample(32'h0000_0000, 32'h8000_0001);
        push_sample(32'h8000_0000, 32'h7FFF_FFFF);
        push_sample(32'hFFFF_FFFF, 32'h0001_FFFF);
        push_sample(32'h0001_0000, 32'h0000_0000);
        push_sample(32'h0000_0000, 32'h0002_0000);
        push_sample(32'h0000_FFFF, 32'hFFFE_0000);
        repeat (3) push_tick();
        push_sample(32'h000A_0000, 32'h0000_0000);
        push_sample(32'hFFF6_0000, 32'h0001_0000);
        push_sample(32'h0000_0000, 32'h0014_0000);
        repeat (5) push_tick();
        push_sample(32'h0064_0000, 32'h0000_0000);
        repeat (4) push_tick();
        drain();

        // no idling, long receiver hold-off while the sender keeps offering
        write_ascending(1'b0);
        write_ascending(1'b1);
        write_reg(REG_TIMEOUT, 31'h7FFF_0005);
        start_phase(0, 0);
        hold_req++;
        gen_random(PHASE_ITEMS);
        drain();

        // sender idles, torque limits out of order, zero timeout
        a = LIMIT_W'($urandom_range(32'h10_0000, 32'h7FFF_FFFF));
        b = LIMIT_W'($urandom_range(32'h1000, a - 1));
        c = LIMIT_W'($urandom_range(0, b - 1));
        write_limits(1'b0, a, b, c);
        write_ascending(1'b1);
        write_reg(REG_TIMEOUT, 31'd0);
        start_phase(63, 0);
        gen_random(PHASE_ITEMS);
        drain();

        // receiver stalls, torque limits at maximum, speed level one at zero
        write_limits(1'b0, LIMIT_RESET, LIMIT_RESET, LIMIT_RESET);
        a = LIMIT_W'($urandom_range(32'h100, 32'h10_0000));
        write_limits(1'b1, '0, a, LIMIT_W'(a + $urandom_range(0, 32'h100_0000)));
        write_reg(REG_TIMEOUT, 31'd1);
        start_phase(0, 63);
        gen_random(PHASE_ITEMS);
        drain();

        // both sides idle
        write_ascending(1'b0);
        write_ascending(1'b1);
        write_reg(REG_TIMEOUT, CFG_DATA_W'($urandom_range(2, 12)));
        start_phase(31, 31);
        gen_random(PHASE_ITEMS);
        drain();

        repeat (10) @(posedge aclk);
        if (level_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", level_q.size()));
        $display("Covered %0d status samples and %0d ticks across five idle/stall mixes,",
                 n_samples, n_ticks);
        $display("%0d results checked, %0d escalation requests, %0d watchdog fires, %0d mismatches",
                 n_results, n_requests, n_fires, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
